FILE: rtl/tct_pkg.sv
// Package with the transaction types and constants of the connection tracking table.
`default_nettype none
package tct_pkg;
  localparam logic [3:0] StEstablished = 4'd1;
  localparam logic [3:0] StClose       = 4'd7;
  localparam logic       FuncState     = 1'b0;
  localparam logic       FuncRetx      = 1'b1;
  localparam int unsigned KeyW         = 96;

  typedef struct packed {
    logic        func;
    logic        is_ipv4;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [3:0]  new_state;
    logic [63:0] now_ns;
  } tct_in_t;

  typedef struct packed {
    logic [31:0] out_src_ip;
    logic [31:0] out_dst_ip;
    logic [15:0] out_src_port;
    logic [15:0] out_dst_port;
    logic [63:0] end_time_ns;
    logic [63:0] elapsed_ns;
    logic [31:0] retransmits;
  } tct_out_t;
endpackage
`default_nettype wire

FILE: rtl/tct_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none
module tct_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

FILE: rtl/tcp_connection_tracking_table.sv
// Top level of the TCP connection tracking table: sequencer around two keyed memories.
// Each accepted transaction scans both tables, one entry of each per cycle, through
// memories with a registered read, and busy is high for the scan and the update.
// At most one result per item, shown for one cycle on valid_o; the receiver cannot
// stall it.
// Reset clears the valid bits and the sequencer at once.
`default_nettype none
module tcp_connection_tracking_table
  import tct_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     start,
  output logic          busy,
  input  wire tct_in_t  in_i,
  output logic          valid_o,
  output tct_out_t      out_o
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = AW + 1;
  localparam int unsigned RamD = 1 << AW;

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_UPD} state_e;
  state_e      state_q;
  tct_in_t     item_q;
  logic [CW-1:0] rd_q;      // address issued
  logic        rv_q;        // read data valid for rd_q-1
  logic [AW-1:0] lag_q;
  logic        chit_q, rhit_q, cfree_q, rfree_q;
  logic [AW-1:0] cidx_q, ridx_q, cfidx_q, rfidx_q;
  logic [63:0] cstart_q;
  logic [31:0] rcnt_q;
  logic [TABLE_DEPTH-1:0] cval_q, rval_q;

  logic [KeyW+63:0] conn_rd;
  logic [KeyW+31:0] retx_rd;
  logic [KeyW-1:0] ckey_rd, rkey_rd;
  logic [63:0] cstart_rd;
  logic [31:0] rcnt_rd;
  logic ck_we, rk_we, cs_we, rc_we;
  logic [AW-1:0] ck_wa, rk_wa;
  logic [KeyW-1:0] key;
  logic [31:0] rc_wd;
  logic [AW-1:0] raddr;

  assign key   = {item_q.src_ip, item_q.dst_ip, item_q.sport, item_q.dport};
  assign raddr = rd_q[AW-1:0];
  assign busy  = (state_q != S_IDLE);

  assign ckey_rd   = conn_rd[KeyW+63:64];
  assign cstart_rd = conn_rd[63:0];
  assign rkey_rd   = retx_rd[KeyW+31:32];
  assign rcnt_rd   = retx_rd[31:0];

  // Each entry holds the tuple with its start time or its retransmit count.
  tct_ram #(.Width(KeyW+64), .Depth(RamD)) u_conn (.clk_i, .we_i(cs_we), .waddr_i(ck_wa),
    .wdata_i({key, item_q.now_ns}), .raddr_i(raddr), .rdata_o(conn_rd));
  tct_ram #(.Width(KeyW+32), .Depth(RamD)) u_retx (.clk_i, .we_i(rc_we), .waddr_i(rk_wa),
    .wdata_i({key, rc_wd}), .raddr_i(raddr), .rdata_o(retx_rd));

  logic is_retx, is_est, is_close;
  assign is_retx  = item_q.func == FuncRetx;
  assign is_est   = item_q.func == FuncState && item_q.new_state == StEstablished;
  assign is_close = item_q.func == FuncState && item_q.new_state == StClose;

  // Write side of the update cycle.
  always_comb begin
    ck_wa = chit_q ? cidx_q : cfidx_q;
    rk_wa = rhit_q ? ridx_q : rfidx_q;
    ck_we = (state_q == S_UPD) && is_est && !chit_q && cfree_q;
    cs_we = (state_q == S_UPD) && is_est && (chit_q || cfree_q);
    rk_we = (state_q == S_UPD) && is_retx && !rhit_q && rfree_q;
    rc_we = (state_q == S_UPD) && is_retx && (rhit_q || rfree_q);
    rc_wd = rhit_q ? rcnt_q + 32'd1 : 32'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cval_q  <= '0;
      rval_q  <= '0;
      valid_o <= 1'b0;
      rd_q    <= '0;
      rv_q    <= 1'b0;
      chit_q  <= 1'b0;
      rhit_q  <= 1'b0;
      cfree_q <= 1'b0;
      rfree_q <= 1'b0;
    end else begin
      valid_o <= (state_q == S_UPD) && is_close && chit_q;
      unique case (state_q)
        S_IDLE: begin
          if (start && in_i.is_ipv4 && (in_i.func == FuncRetx ||
              in_i.new_state == StEstablished || in_i.new_state == StClose)) begin
            item_q  <= in_i;
            state_q <= S_SCAN;
            rd_q    <= '0;
            rv_q    <= 1'b0;
            chit_q  <= 1'b0;
            rhit_q  <= 1'b0;
            cfree_q <= 1'b0;
            rfree_q <= 1'b0;
          end
        end
        S_SCAN: begin
          if (rd_q < CW'(TABLE_DEPTH)) rd_q <= rd_q + 1'b1;
          lag_q <= raddr;
          rv_q  <= rd_q < CW'(TABLE_DEPTH);
          if (rv_q) begin
            // The first hit and the lowest free slot win.
            if (cval_q[lag_q] && ckey_rd == key && !chit_q) begin
              chit_q <= 1'b1; cidx_q <= lag_q; cstart_q <= cstart_rd;
            end
            if (rval_q[lag_q] && rkey_rd == key && !rhit_q) begin
              rhit_q <= 1'b1; ridx_q <= lag_q; rcnt_q <= rcnt_rd;
            end
            if (!cval_q[lag_q] && !cfree_q) begin
              cfree_q <= 1'b1; cfidx_q <= lag_q;
            end
            if (!rval_q[lag_q] && !rfree_q) begin
              rfree_q <= 1'b1; rfidx_q <= lag_q;
            end
          end else if (rd_q == CW'(TABLE_DEPTH)) begin
            state_q <= S_UPD;
          end
        end
        S_UPD: begin
          state_q <= S_IDLE;
          if (ck_we) cval_q[cfidx_q] <= 1'b1;
          if (rk_we) rval_q[rfidx_q] <= 1'b1;
          if (is_close && chit_q) begin
            cval_q[cidx_q] <= 1'b0;
            if (rhit_q) rval_q[ridx_q] <= 1'b0;
            out_o <= '{out_src_ip: item_q.src_ip, out_dst_ip: item_q.dst_ip,
                       out_src_port: item_q.sport, out_dst_port: item_q.dport,
                       end_time_ns: item_q.now_ns,
                       elapsed_ns: item_q.now_ns - cstart_q,
                       retransmits: rhit_q ? rcnt_q : 32'd0};
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/tct_checker.sv
// Port-level checker for the connection tracking table, bound to the top level.
`default_nettype none
module tct_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire logic valid_o
);
  // A result only ends a transaction.
  a_res_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy && $past(busy)) else $error("result outside transaction end");
  a_res_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |=> !valid_o) else $error("result repeated");
  a_busy_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start)) else $error("busy without start");
  a_busy_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |=> busy) else $error("transaction too short");
endmodule
bind tcp_connection_tracking_table tct_checker u_chk (.clk_i, .rst_ni, .start, .busy,
  .valid_o);
`default_nettype wire
